FILE: rtl/flptw_pkg.sv
// shared constants, codes and types of the four-level page table walker
package flptw_pkg;

   localparam int NUM_FRAMES        = 64;
   localparam int ENTRIES_PER_TABLE = 512;

   localparam int IDX_W   = $clog2(ENTRIES_PER_TABLE);
   localparam int FRAME_W = (NUM_FRAMES > 2) ? $clog2(NUM_FRAMES) : 1;
   localparam int NF_W    = FRAME_W + 1;
   localparam int ADDR_W  = FRAME_W + IDX_W;
   localparam int DEPTH   = NUM_FRAMES * ENTRIES_PER_TABLE;

   localparam int CFG_W   = 6;
   localparam int CNT_W   = (CFG_W > NF_W) ? CFG_W : NF_W;
   localparam int CSR_IDX_W = 2;

   localparam int VA_W    = 48;
   localparam int PA_W    = 52;
   localparam int FLAG_W  = 12;
   localparam int ENTRY_W = 64;
   localparam int ADDR_LO = 12;
   localparam int ADDR_HI = 51;
   localparam int FNUM_W  = ADDR_HI - ADDR_LO + 1;

   localparam logic [ENTRY_W-1:0] ENT_PRESENT  = 64'h1;
   localparam logic [ENTRY_W-1:0] ENT_WRITABLE = 64'h2;
   localparam logic [ENTRY_W-1:0] ENT_LARGE    = 64'h80;

   localparam int BIT_PRESENT = 0;
   localparam int BIT_LARGE   = 7;

   localparam logic [1:0] MODE_LOOKUP = 2'd0;
   localparam logic [1:0] MODE_MAP4K  = 2'd1;
   localparam logic [1:0] MODE_MAP2M  = 2'd2;
   localparam logic [1:0] MODE_UNMAP  = 2'd3;

   localparam logic [1:0] ST_OK          = 2'd0;
   localparam logic [1:0] ST_NOT_PRESENT = 2'd1;
   localparam logic [1:0] ST_NO_FRAMES   = 2'd2;
   localparam logic [1:0] ST_RANGE       = 2'd3;

   localparam logic [1:0] LVL_PT   = 2'd0;
   localparam logic [1:0] LVL_PD   = 2'd1;
   localparam logic [1:0] LVL_PDPT = 2'd2;
   localparam logic [1:0] LVL_PML4 = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_ROOT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ALLOC = 2'd1;

   typedef struct packed {
      logic               present;
      logic               big_page;
      logic               frame_ok;
      logic [FRAME_W-1:0] frame;
   } entry_info_type;

endpackage

FILE: rtl/flptw_ram.sv
// generic single-port ram with registered read
module flptw_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/flptw_entry_unit.sv
// shared entry unit: table index select and entry decode with frame range check
module flptw_entry_unit (
   input  logic [flptw_pkg::ENTRY_W-1:0] entry,
   input  logic [flptw_pkg::VA_W-1:0]    va,
   input  logic [1:0]                    lvl,
   output logic [flptw_pkg::IDX_W-1:0]   idx,
   output flptw_pkg::entry_info_type     info
);
   import flptw_pkg::*;

   logic [FNUM_W-1:0] fnum;

   assign fnum = entry[ADDR_HI:ADDR_LO];

   always_comb begin
      unique case (lvl)
         LVL_PT:   idx = va[ADDR_LO +: IDX_W];
         LVL_PD:   idx = va[ADDR_LO + IDX_W +: IDX_W];
         LVL_PDPT: idx = va[ADDR_LO + 2*IDX_W +: IDX_W];
         default:  idx = va[ADDR_LO + 3*IDX_W +: IDX_W];
      endcase
   end

   assign info.present  = entry[BIT_PRESENT];
   assign info.big_page = entry[BIT_LARGE];
   assign info.frame_ok = (fnum < FNUM_W'(NUM_FRAMES));
   assign info.frame    = fnum[FRAME_W-1:0];

endmodule

FILE: rtl/flptw_ctrl.sv
// walk sequencer: clearing sweeps, level walk, frame allocation and result register
module flptw_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [1:0]                      req_mode,
   input  logic [flptw_pkg::VA_W-1:0]      req_virt_addr,
   input  logic [flptw_pkg::PA_W-1:0]      req_phys_addr,
   input  logic [flptw_pkg::FLAG_W-1:0]    req_entry_flags,
   output logic                            rsp_valid,
   output logic [1:0]                      rsp_status,
   output logic [flptw_pkg::ENTRY_W-1:0]   rsp_entry_value,
   output logic [flptw_pkg::PA_W-1:0]      rsp_frame_addr,
   output logic [1:0]                      rsp_level,
   output logic                            rsp_invalidate,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [flptw_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [flptw_pkg::CFG_W-1:0]     csr_wdata,
   output logic                            mem_we,
   output logic [flptw_pkg::ADDR_W-1:0]    mem_addr,
   output logic [flptw_pkg::ENTRY_W-1:0]   mem_wdata,
   input  logic [flptw_pkg::ENTRY_W-1:0]   mem_rdata
);
   import flptw_pkg::*;

   localparam logic [2:0] S_INIT = 3'd0;
   localparam logic [2:0] S_IDLE = 3'd1;
   localparam logic [2:0] S_RD   = 3'd2;
   localparam logic [2:0] S_EVAL = 3'd3;
   localparam logic [2:0] S_ZERO = 3'd4;
   localparam logic [2:0] S_LINK = 3'd5;

   logic [2:0]         state_ff, state_in;
   logic [ADDR_W-1:0]  clr_cnt_ff, clr_cnt_in;
   logic [1:0]         mode_ff, mode_in;
   logic [VA_W-1:0]    va_ff, va_in;
   logic [PA_W-1:0]    pa_ff, pa_in;
   logic [FLAG_W-1:0]  fl_ff, fl_in;
   logic [1:0]         lvl_ff, lvl_in;
   logic [FRAME_W-1:0] cur_ff, cur_in;
   logic [ADDR_W-1:0]  slot_ff, slot_in;
   logic [FRAME_W-1:0] nf_ff, nf_in;
   logic [CNT_W-1:0]   next_free_ff, next_free_in;
   logic [CFG_W-1:0]   root_ff, root_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic [ENTRY_W-1:0] rsp_ev_ff, rsp_ev_in;
   logic [1:0]         rsp_level_ff, rsp_level_in;
   logic               rsp_inv_ff, rsp_inv_in;

   logic [IDX_W-1:0]   idx;
   entry_info_type     info;
   logic [CNT_W-1:0]   root_ext;
   logic               is_map;
   logic [ENTRY_W-1:0] map_base;

   flptw_entry_unit u_entry (
      .entry (mem_rdata),
      .va    (va_ff),
      .lvl   (lvl_ff),
      .idx   (idx),
      .info  (info)
   );

   assign root_ext = CNT_W'(root_ff);
   assign is_map   = (mode_ff == MODE_MAP4K) || (mode_ff == MODE_MAP2M);
   assign map_base = ENTRY_W'(pa_ff) | ENTRY_W'(fl_ff) | ENT_PRESENT;

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      mode_in      = mode_ff;
      va_in        = va_ff;
      pa_in        = pa_ff;
      fl_in        = fl_ff;
      lvl_in       = lvl_ff;
      cur_in       = cur_ff;
      slot_in      = slot_ff;
      nf_in        = nf_ff;
      next_free_in = next_free_ff;
      root_in      = root_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_ev_in     = rsp_ev_ff;
      rsp_level_in  = rsp_level_ff;
      rsp_inv_in    = rsp_inv_ff;
      mem_we    = 1'b0;
      mem_addr  = {cur_ff, idx};
      mem_wdata = '0;

      unique case (state_ff)
         S_INIT: begin
            // zero the whole store once after reset
            mem_we     = 1'b1;
            mem_addr   = clr_cnt_ff;
            clr_cnt_in = ADDR_W'(clr_cnt_ff + 1'b1);
            if (clr_cnt_ff == ADDR_W'(DEPTH - 1)) begin
               clr_cnt_in = '0;
               state_in   = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               mode_in = req_mode;
               va_in   = req_virt_addr;
               pa_in   = req_phys_addr;
               fl_in   = req_entry_flags;
               lvl_in  = LVL_PML4;
               cur_in  = root_ext[FRAME_W-1:0];
               if (root_ext >= CNT_W'(NUM_FRAMES)) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_RANGE;
                  rsp_ev_in     = '0;
                  rsp_level_in  = LVL_PML4;
                  rsp_inv_in    = 1'b0;
               end else begin
                  state_in = S_RD;
               end
            end
         end
         S_RD: begin
            if (mode_ff == MODE_MAP4K && lvl_ff == LVL_PT) begin
               mem_we        = 1'b1;
               mem_wdata     = map_base;
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_ev_in     = map_base;
               rsp_level_in  = LVL_PT;
               rsp_inv_in    = 1'b1;
               state_in      = S_IDLE;
            end else if (mode_ff == MODE_MAP2M && lvl_ff == LVL_PD) begin
               mem_we        = 1'b1;
               mem_wdata     = map_base | ENT_LARGE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_ev_in     = map_base | ENT_LARGE;
               rsp_level_in  = LVL_PD;
               rsp_inv_in    = 1'b1;
               state_in      = S_IDLE;
            end else begin
               slot_in  = {cur_ff, idx};
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            rsp_ev_in    = '0;
            rsp_level_in = lvl_ff;
            rsp_inv_in   = 1'b0;
            if (is_map) begin
               if (!info.present) begin
                  if (next_free_ff >= CNT_W'(NUM_FRAMES)) begin
                     next_free_in  = CNT_W'(NUM_FRAMES);
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_NO_FRAMES;
                     state_in      = S_IDLE;
                  end else begin
                     nf_in        = next_free_ff[FRAME_W-1:0];
                     next_free_in = CNT_W'(next_free_ff + 1'b1);
                     clr_cnt_in   = '0;
                     state_in     = S_ZERO;
                  end
               end else if (!info.frame_ok) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_RANGE;
                  state_in      = S_IDLE;
               end else begin
                  // map descends through large entries as if they were tables
                  cur_in   = info.frame;
                  lvl_in   = 2'(lvl_ff - 2'd1);
                  state_in = S_RD;
               end
            end else begin
               if (!info.present) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_NOT_PRESENT;
                  state_in      = S_IDLE;
               end else if (lvl_ff == LVL_PT || info.big_page) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_OK;
                  rsp_ev_in     = mem_rdata;
                  state_in      = S_IDLE;
                  if (mode_ff == MODE_UNMAP) begin
                     mem_we     = 1'b1;
                     mem_addr   = slot_ff;
                     rsp_inv_in = 1'b1;
                  end
               end else if (!info.frame_ok) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_RANGE;
                  state_in      = S_IDLE;
               end else begin
                  cur_in   = info.frame;
                  lvl_in   = 2'(lvl_ff - 2'd1);
                  state_in = S_RD;
               end
            end
         end
         S_ZERO: begin
            // clear the new table before linking it, it may be the current one
            mem_we     = 1'b1;
            mem_addr   = {nf_ff, clr_cnt_ff[IDX_W-1:0]};
            clr_cnt_in = ADDR_W'(clr_cnt_ff + 1'b1);
            if (clr_cnt_ff[IDX_W-1:0] == '1) begin
               clr_cnt_in = '0;
               state_in   = S_LINK;
            end
         end
         S_LINK: begin
            mem_we    = 1'b1;
            mem_addr  = slot_ff;
            mem_wdata = (ENTRY_W'(nf_ff) << ADDR_LO) | ENT_PRESENT | ENT_WRITABLE;
            cur_in    = nf_ff;
            lvl_in    = 2'(lvl_ff - 2'd1);
            state_in  = S_RD;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_valid) begin
         unique case (csr_index)
            CSR_ROOT:  root_in      = csr_wdata;
            CSR_ALLOC: next_free_in = CNT_W'(csr_wdata);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         clr_cnt_ff   <= '0;
         next_free_ff <= CNT_W'(1);
         root_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         next_free_ff <= next_free_in;
         root_ff      <= root_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      va_ff         <= va_in;
      pa_ff         <= pa_in;
      fl_ff         <= fl_in;
      lvl_ff        <= lvl_in;
      cur_ff        <= cur_in;
      slot_ff       <= slot_in;
      nf_ff         <= nf_in;
      rsp_status_ff <= rsp_status_in;
      rsp_ev_ff     <= rsp_ev_in;
      rsp_level_ff  <= rsp_level_in;
      rsp_inv_ff    <= rsp_inv_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_value = rsp_ev_ff;
   assign rsp_frame_addr  = {rsp_ev_ff[ADDR_HI:ADDR_LO], ADDR_LO'(0)};
   assign rsp_level       = rsp_level_ff;
   assign rsp_invalidate  = rsp_inv_ff;

endmodule

FILE: rtl/four_level_page_table_map_walk_top.sv
// top level of the four-level page table walker with its own table store
//
// A request is taken when start is high and busy is low; busy stays high until its
// result has been registered, and the result is shown on the rsp_ ports for exactly
// one cycle with rsp_valid high, with no way for the receiver to stall it. The walk
// reads one table entry per level through a single port of the table ram, reading
// each entry in S_RD and deciding on it in S_EVAL; a map writes its last entry from
// S_RD itself. Every table the allocator hands out is first zeroed, one entry a
// cycle, and then linked in from S_LINK. After reset busy stays high while the
// whole store, NUM_FRAMES*512 entries (32768 by default), is zeroed; configuration
// writes are taken at any time, csr_ready is always high, and a write of alloc_start
// also restarts the frame allocator there.
module four_level_page_table_map_walk_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [1:0]                      req_mode,
   input  logic [flptw_pkg::VA_W-1:0]      req_virt_addr,
   input  logic [flptw_pkg::PA_W-1:0]      req_phys_addr,
   input  logic [flptw_pkg::FLAG_W-1:0]    req_entry_flags,
   output logic                            rsp_valid,
   output logic [1:0]                      rsp_status,
   output logic [flptw_pkg::ENTRY_W-1:0]   rsp_entry_value,
   output logic [flptw_pkg::PA_W-1:0]      rsp_frame_addr,
   output logic [1:0]                      rsp_level,
   output logic                            rsp_invalidate,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [flptw_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [flptw_pkg::CFG_W-1:0]     csr_wdata
);
   import flptw_pkg::*;

   logic               mem_we;
   logic [ADDR_W-1:0]  mem_addr;
   logic [ENTRY_W-1:0] mem_wdata;
   logic [ENTRY_W-1:0] mem_rdata;

   flptw_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_mode        (req_mode),
      .req_virt_addr   (req_virt_addr),
      .req_phys_addr   (req_phys_addr),
      .req_entry_flags (req_entry_flags),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_entry_value (rsp_entry_value),
      .rsp_frame_addr  (rsp_frame_addr),
      .rsp_level       (rsp_level),
      .rsp_invalidate  (rsp_invalidate),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mem_we          (mem_we),
      .mem_addr        (mem_addr),
      .mem_wdata       (mem_wdata),
      .mem_rdata       (mem_rdata)
   );

   flptw_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_table_ram (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

endmodule

FILE: bench/walk_checker.sv
`timescale 1ns / 1ps
// checker of the page table walker: shadows the table store, predicts each result and compares
module walk_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            busy,
   input  logic [1:0]                      req_mode,
   input  logic [flptw_pkg::VA_W-1:0]      req_virt_addr,
   input  logic [flptw_pkg::PA_W-1:0]      req_phys_addr,
   input  logic [flptw_pkg::FLAG_W-1:0]    req_entry_flags,
   input  logic                            rsp_valid,
   input  logic [1:0]                      rsp_status,
   input  logic [flptw_pkg::ENTRY_W-1:0]   rsp_entry_value,
   input  logic [flptw_pkg::PA_W-1:0]      rsp_frame_addr,
   input  logic [1:0]                      rsp_level,
   input  logic                            rsp_invalidate,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [flptw_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [flptw_pkg::CFG_W-1:0]     csr_wdata,
   output int unsigned                     mismatches,
   output int unsigned                     outstanding
);
   import flptw_pkg::*;

   typedef struct packed {
      logic [1:0]         status;
      logic [ENTRY_W-1:0] entry_value;
      logic [PA_W-1:0]    frame_addr;
      logic [1:0]         level;
      logic               invalidate;
   } walk_result_type;

   logic [ENTRY_W-1:0] frame_mem [DEPTH];
   logic [FRAME_W-1:0] root_fr;
   logic [NF_W-1:0]    alloc_next;
   walk_result_type    pending_q [$];
   walk_result_type    want;
   int unsigned        results_seen;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] exp_val);
      $display("mismatch on result %0d, %s: got %h, expected %h",
               results_seen, what, got, exp_val);
      mismatches++;
   endtask

   function automatic logic alloc_table(output logic [FRAME_W-1:0] fr);
      fr = '0;
      if (alloc_next >= NUM_FRAMES) begin
         alloc_next = NF_W'(NUM_FRAMES);
         return 1'b0;
      end
      fr = alloc_next[FRAME_W-1:0];
      alloc_next++;
      for (int i = 0; i < ENTRIES_PER_TABLE; i++) frame_mem[{fr, IDX_W'(i)}] = '0;
      return 1'b1;
   endfunction

   function automatic walk_result_type predict_walk(input logic [1:0] mode,
                                                    input logic [VA_W-1:0] va,
                                                    input logic [PA_W-1:0] pa,
                                                    input logic [FLAG_W-1:0] fl);
      walk_result_type    r;
      logic [FRAME_W-1:0] cur;
      logic [FRAME_W-1:0] nf;
      logic [ADDR_W-1:0]  slot;
      logic [ENTRY_W-1:0] ent;
      logic [ENTRY_W-1:0] found;
      logic [FNUM_W-1:0]  fnum;
      logic [1:0]         st;
      logic [1:0]         lvl;
      logic               done;
      logic               is_map;
      int                 l;
      r      = '0;
      st     = ST_OK;
      lvl    = LVL_PML4;
      found  = '0;
      done   = 1'b0;
      cur    = root_fr;
      is_map = (mode == MODE_MAP4K) || (mode == MODE_MAP2M);
      if (int'(root_fr) >= NUM_FRAMES) begin
         st   = ST_RANGE;
         done = 1'b1;
      end
      l = LVL_PML4;
      // every path ends by the pt level at the latest
      while (!done) begin
         slot = {cur, va[ADDR_LO + IDX_W*l +: IDX_W]};
         lvl  = 2'(l);
         ent  = frame_mem[slot];
         if (is_map && (l == LVL_PT || (l == LVL_PD && mode == MODE_MAP2M))) begin
            found = {{(ENTRY_W-PA_W){1'b0}}, pa} | ENT_PRESENT | ENTRY_W'(fl);
            if (l == LVL_PD) found = found | ENT_LARGE;
            frame_mem[slot] = found;
            done = 1'b1;
         end else if (is_map) begin
            if (!ent[BIT_PRESENT]) begin
               if (!alloc_table(nf)) begin
                  st   = ST_NO_FRAMES;
                  done = 1'b1;
               end else begin
                  ent = (ENTRY_W'(nf) << ADDR_LO) | ENT_PRESENT | ENT_WRITABLE;
                  frame_mem[slot] = ent;
               end
            end
         end else if (!ent[BIT_PRESENT]) begin
            st   = ST_NOT_PRESENT;
            done = 1'b1;
         end else if (l == LVL_PT || ent[BIT_LARGE]) begin
            found = ent;
            if (mode == MODE_UNMAP) frame_mem[slot] = '0;
            done = 1'b1;
         end
         // descend: maps go through large entries too
         if (!done) begin
            fnum = ent[ADDR_HI:ADDR_LO];
            if (fnum >= NUM_FRAMES) begin
               st   = ST_RANGE;
               done = 1'b1;
            end else begin
               cur = fnum[FRAME_W-1:0];
            end
         end
         l--;
      end
      r.status = st;
      r.level  = lvl;
      if (st == ST_OK) begin
         r.entry_value = found;
         r.frame_addr  = found[PA_W-1:0] & {{FNUM_W{1'b1}}, {ADDR_LO{1'b0}}};
         r.invalidate  = (mode != MODE_LOOKUP);
      end
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         foreach (frame_mem[i]) frame_mem[i] = '0;
         root_fr      = '0;
         alloc_next   = NF_W'(1);
         results_seen = 0;
         mismatches   = 0;
         pending_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ROOT: begin
                  root_fr = csr_wdata;
               end
               CSR_ALLOC: begin
                  alloc_next = NF_W'(csr_wdata);
               end
               default: ;
            endcase
         end
         if (rsp_valid) begin
            if (pending_q.size() == 0) begin
               report_mismatch("result with no item pending", rsp_entry_value, '0);
            end else begin
               want = pending_q.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", 64'(rsp_status), 64'(want.status));
               if (rsp_entry_value !== want.entry_value)
                  report_mismatch("entry_value", rsp_entry_value, want.entry_value);
               if (rsp_frame_addr !== want.frame_addr)
                  report_mismatch("frame_addr", 64'(rsp_frame_addr), 64'(want.frame_addr));
               if (rsp_level !== want.level)
                  report_mismatch("level", 64'(rsp_level), 64'(want.level));
               if (rsp_invalidate !== want.invalidate)
                  report_mismatch("invalidate", 64'(rsp_invalidate), 64'(want.invalidate));
            end
            results_seen++;
         end
         if (start && !busy)
            pending_q.push_back(predict_walk(req_mode, req_virt_addr, req_phys_addr,
                                             req_entry_flags));
      end
      outstanding <= pending_q.size();
   end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// testbench top of the page table walker: clock, reset, request and register stimulus, verdict
module tb;
   import flptw_pkg::*;

   localparam int WATCHDOG_LIMIT  = 140000;
   localparam int NUM_PHASES      = 4;
   localparam int ITEMS_PER_PHASE = 95;

   typedef struct packed {
      logic [1:0]        mode;
      logic [VA_W-1:0]   va;
      logic [PA_W-1:0]   pa;
      logic [FLAG_W-1:0] fl;
   } walk_req_type;

   logic                 clock           = 1'b0;
   logic                 reset           = 1'b1;
   logic                 start           = 1'b0;
   logic [1:0]           req_mode        = MODE_LOOKUP;
   logic [VA_W-1:0]      req_virt_addr   = '0;
   logic [PA_W-1:0]      req_phys_addr   = '0;
   logic [FLAG_W-1:0]    req_entry_flags = '0;
   logic                 csr_valid       = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index       = CSR_ROOT;
   logic [CFG_W-1:0]     csr_wdata       = '0;
   logic                 busy;
   logic                 rsp_valid;
   logic [1:0]           rsp_status;
   logic [ENTRY_W-1:0]   rsp_entry_value;
   logic [PA_W-1:0]      rsp_frame_addr;
   logic [1:0]           rsp_level;
   logic                 rsp_invalidate;
   logic                 csr_ready;
   int unsigned          mismatches;
   int unsigned          outstanding;

   logic [VA_W-1:0] va_pool [$];
   int              mode_count [4];
   int              items_sent    = 0;
   int              settings_used = 0;
   int              stall_cycles  = 0;

   four_level_page_table_map_walk_top DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_mode        (req_mode),
      .req_virt_addr   (req_virt_addr),
      .req_phys_addr   (req_phys_addr),
      .req_entry_flags (req_entry_flags),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_entry_value (rsp_entry_value),
      .rsp_frame_addr  (rsp_frame_addr),
      .rsp_level       (rsp_level),
      .rsp_invalidate  (rsp_invalidate),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   walk_checker checker_inst (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_mode        (req_mode),
      .req_virt_addr   (req_virt_addr),
      .req_phys_addr   (req_phys_addr),
      .req_entry_flags (req_entry_flags),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_entry_value (rsp_entry_value),
      .rsp_frame_addr  (rsp_frame_addr),
      .rsp_level       (rsp_level),
      .rsp_invalidate  (rsp_invalidate),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatches      (mismatches),
      .outstanding     (outstanding)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // no handshake for too long: covers the clearing pass after reset several times over
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: %0d cycles without any handshake", stall_cycles);
         $display("== FAIL ==");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   function automatic walk_req_type build_req(input logic [1:0] mode,
                                              input logic [VA_W-1:0] va,
                                              input logic [PA_W-1:0] pa,
                                              input logic [FLAG_W-1:0] fl);
      walk_req_type q;
      q.mode = mode;
      q.va   = va;
      q.pa   = pa;
      q.fl   = fl;
      return q;
   endfunction

   function automatic logic [VA_W-1:0] vaddr(input logic [IDX_W-1:0] i3, input logic [IDX_W-1:0] i2,
                                             input logic [IDX_W-1:0] i1, input logic [IDX_W-1:0] i0);
      return {i3, i2, i1, i0, 12'h000};
   endfunction

   // mostly a few low indexes per level so walks share tables
   function automatic logic [IDX_W-1:0] pick_index();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) return IDX_W'($urandom_range(0, 3));
      if (r < 80) return '1;
      return IDX_W'($urandom_range(0, ENTRIES_PER_TABLE - 1));
   endfunction

   function automatic logic [VA_W-1:0] fresh_va();
      if ($urandom_range(0, 9) == 0) return VA_W'({$urandom, $urandom});
      return vaddr(pick_index(), pick_index(), pick_index(), pick_index())
             | VA_W'($urandom_range(0, 4095));
   endfunction

   function automatic logic [VA_W-1:0] recall_va();
      logic [VA_W-1:0] v;
      v = va_pool[$urandom_range(0, va_pool.size() - 1)];
      v[ADDR_LO-1:0] = ADDR_LO'($urandom_range(0, 4095));
      // other pt slot under the same pd, or inside a large page
      if ($urandom_range(0, 3) == 0) v[ADDR_LO +: IDX_W] = pick_index();
      return v;
   endfunction

   // small frame numbers make entries usable as table pointers
   function automatic logic [PA_W-1:0] pick_pa();
      logic [PA_W-1:0] low;
      low = PA_W'($urandom_range(0, 4095));
      case ($urandom_range(0, 2))
         0:       return PA_W'({$urandom, $urandom});
         1:       return (PA_W'($urandom_range(0, NUM_FRAMES - 1)) << ADDR_LO) | low;
         default: return (PA_W'($urandom_range(NUM_FRAMES, 3 * NUM_FRAMES)) << ADDR_LO) | low;
      endcase
   endfunction

   function automatic walk_req_type random_req();
      walk_req_type q;
      int unsigned  r;
      logic         is_map;
      logic         reuse;
      r = $urandom_range(0, 99);
      if (r < 30)      q.mode = MODE_MAP4K;
      else if (r < 45) q.mode = MODE_MAP2M;
      else if (r < 75) q.mode = MODE_LOOKUP;
      else             q.mode = MODE_UNMAP;
      is_map = (q.mode == MODE_MAP4K) || (q.mode == MODE_MAP2M);
      reuse  = ($urandom_range(0, 99) < (is_map ? 40 : 80)) && (va_pool.size() != 0);
      q.va   = reuse ? recall_va() : fresh_va();
      q.pa   = pick_pa();
      q.fl   = FLAG_W'($urandom_range(0, 4095));
      if (is_map) begin
         va_pool.push_back(q.va);
         if (va_pool.size() > 48) void'(va_pool.pop_front());
      end
      return q;
   endfunction

   task automatic issue(input walk_req_type q);
      logic quiet;
      quiet = (items_sent >= 120) && (items_sent < 200);
      if (!quiet && $urandom_range(0, 99) < 31) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      start           <= 1'b1;
      req_mode        <= q.mode;
      req_virt_addr   <= q.va;
      req_phys_addr   <= q.pa;
      req_entry_flags <= q.fl;
      do @(posedge clock); while (busy);
      mode_count[q.mode]++;
      items_sent++;
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0 || busy);
   endtask

   task automatic write_cfg(input logic [CFG_W-1:0] root, input logic [CFG_W-1:0] base);
      csr_valid <= 1'b1;
      csr_index <= CSR_ROOT;
      csr_wdata <= root;
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_ALLOC;
      csr_wdata <= base;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      // the block clears its whole store before taking anything
      wait_drained();
      write_cfg(6'd0, 6'd1);

      // empty tables, then full-width fields
      issue(build_req(MODE_LOOKUP, vaddr(0, 0, 0, 0), '0, '0));
      issue(build_req(MODE_UNMAP,  vaddr(0, 0, 0, 0), '0, '0));
      issue(build_req(MODE_MAP4K,  vaddr(0, 0, 0, 0), '0, '0));
      issue(build_req(MODE_LOOKUP, vaddr(0, 0, 0, 0) | VA_W'(12'habc), '0, '0));
      issue(build_req(MODE_MAP4K,  '1, '1, '1));
      issue(build_req(MODE_LOOKUP, '1, '0, '0));
      // large page whose frame is no table, then one pointing at a table frame
      issue(build_req(MODE_MAP2M,  vaddr(0, 1, 1, 0), PA_W'(52'h20_0000), '0));
      issue(build_req(MODE_LOOKUP, vaddr(0, 1, 1, 5), '0, '0));
      issue(build_req(MODE_MAP4K,  vaddr(0, 1, 1, 2), PA_W'(52'h1234_5000), '0));
      issue(build_req(MODE_MAP2M,  vaddr(0, 1, 2, 0), PA_W'(2) << ADDR_LO, '0));
      issue(build_req(MODE_MAP4K,  vaddr(0, 1, 2, 7), PA_W'(52'h7_7000), 12'h006));
      // unmap, then the empty pt slot twice
      issue(build_req(MODE_UNMAP,  vaddr(0, 0, 0, 0), '0, '0));
      issue(build_req(MODE_LOOKUP, vaddr(0, 0, 0, 0), '0, '0));
      issue(build_req(MODE_UNMAP,  vaddr(0, 0, 0, 0), '0, '0));
      issue(build_req(MODE_UNMAP,  vaddr(0, 1, 1, 0), '0, '0));
      // pt entries that turn into pml4 entries once the root moves onto that frame
      issue(build_req(MODE_MAP4K,  vaddr(0, 0, 0, 0), PA_W'(NUM_FRAMES) << ADDR_LO, '0));
      issue(build_req(MODE_MAP4K,  vaddr(0, 0, 0, 1), PA_W'(9) << ADDR_LO, 12'h080));
      wait_drained();
      write_cfg(6'd3, 6'd8);
      issue(build_req(MODE_LOOKUP, vaddr(0, 0, 0, 0), '0, '0));
      issue(build_req(MODE_LOOKUP, vaddr(1, 0, 0, 0), '0, '0));
      issue(build_req(MODE_MAP4K,  vaddr(0, 0, 0, 0), '0, '0));
      issue(build_req(MODE_UNMAP,  vaddr(1, 0, 0, 0), '0, '0));
      // allocator hands out the root frame itself, then runs dry
      wait_drained();
      write_cfg(6'd63, 6'd63);
      issue(build_req(MODE_MAP4K,  vaddr(0, 0, 0, 0), PA_W'(52'h5_5000), 12'h002));
      issue(build_req(MODE_MAP2M,  vaddr(5, 0, 0, 0), '0, '0));
      issue(build_req(MODE_MAP4K,  vaddr(0, 0, 4, 0), '0, '0));
      issue(build_req(MODE_LOOKUP, vaddr(0, 0, 0, 0), '0, '0));

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         wait_drained();
         case (ph)
            0:       write_cfg(6'd0, 6'd1);
            2:       write_cfg(6'd0, CFG_W'($urandom_range(16, 48)));
            default: write_cfg(CFG_W'($urandom_range(0, 63)), CFG_W'($urandom_range(1, 63)));
         endcase
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if ($urandom_range(0, 99) < 3) wait_drained();
            issue(random_req());
         end
      end

      wait_drained();
      repeat (20) @(posedge clock);
      $display("sent %0d requests: %0d lookups, %0d 4K maps, %0d 2M maps, %0d unmaps",
               items_sent, mode_count[MODE_LOOKUP], mode_count[MODE_MAP4K],
               mode_count[MODE_MAP2M], mode_count[MODE_UNMAP]);
      $display("over %0d register settings, %0d mismatches", settings_used, mismatches);
      if (mismatches == 0 && outstanding == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/flptw_pkg.sv
rtl/flptw_ram.sv
rtl/flptw_entry_unit.sv
rtl/flptw_ctrl.sv
rtl/four_level_page_table_map_walk_top.sv
bench/walk_checker.sv
bench/tb.sv
